### sv/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants for the silence segment detector.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int RSP_FIFO_DEPTH = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SILENCE_THRESHOLD  = 2'd0,
      CSR_MIN_SILENCE_LENGTH = 2'd1,
      CSR_MIN_ACTIVE_GAP     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic displace;
      logic flush;
   } emit_type;

endpackage

### sv/silence_segment_detector.sv
// ----------------------------------------------------------------------------
// silence_segment_detector
// Finds runs of silent samples and reports merged silence segments.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while req_tready is high. A request is
// registered, then decided against the segment state once the response
// buffer has room; its responses land in this three-entry response buffer,
// whose head drives rsp_*. A request that both displaces a pending segment and
// flushes at end of stream writes two responses; req_tready drops while a
// registered request waits on a buffer with fewer than two free slots after
// this cycle's pop, so sustained throughput is one request per cycle whenever
// responses are taken at the rate they are made. Configuration writes
// are always accepted and registered.
// ----------------------------------------------------------------------------
module silence_segment_detector #(
   parameter int INDEX_BITS  = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,

   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,   // sample
   input  logic                                   req_tlast,   // end_of_stream

   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((2*INDEX_BITS+7)/8)*8-1:0]      rsp_tdata,   // seg_start, seg_end
   output logic                                   rsp_tuser,   // final_segment
   output logic                                   rsp_tlast,   // last_of_item

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ssd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [((SAMPLE_BITS > INDEX_BITS) ? SAMPLE_BITS : INDEX_BITS)-1:0] csr_data
);

   localparam int ENTRY_BITS = 2 * INDEX_BITS + 2;
   localparam int RSP_BITS   = ((2 * INDEX_BITS + 7) / 8) * 8;

   logic [SAMPLE_BITS-1:0] silence_threshold_ff;
   logic [INDEX_BITS-1:0]  min_silence_length_ff;
   logic [INDEX_BITS-1:0]  min_active_gap_ff;

   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff;
   logic                   in_eos_ff;

   logic                   req_accept;
   logic                   advance;
   logic                   room_two;

   ssd_pkg::emit_type      emit;
   logic [INDEX_BITS-1:0]  old_start, old_end, new_start, new_end;
   logic [ENTRY_BITS-1:0]  disp_entry, flush_entry;
   logic                   wr0_valid, wr1_valid;
   logic [ENTRY_BITS-1:0]  wr0_data;
   logic [ENTRY_BITS-1:0]  head;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;
   assign advance    = in_valid_ff && room_two;
   assign req_tready = !in_valid_ff || room_two;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
         in_eos_ff    <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         silence_threshold_ff  <= '0;
         min_silence_length_ff <= '0;
         min_active_gap_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ssd_pkg::CSR_SILENCE_THRESHOLD: begin
               silence_threshold_ff <= csr_data[SAMPLE_BITS-1:0];
            end
            ssd_pkg::CSR_MIN_SILENCE_LENGTH: begin
               min_silence_length_ff <= csr_data[INDEX_BITS-1:0];
            end
            ssd_pkg::CSR_MIN_ACTIVE_GAP: begin
               min_active_gap_ff <= csr_data[INDEX_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   ssd_seg_core #(
      .INDEX_BITS (INDEX_BITS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .sample            (in_sample_ff),
      .end_of_stream     (in_eos_ff),
      .silence_threshold (silence_threshold_ff),
      .min_silence_length(min_silence_length_ff),
      .min_active_gap    (min_active_gap_ff),
      .emit              (emit),
      .old_start         (old_start),
      .old_end           (old_end),
      .new_start         (new_start),
      .new_end           (new_end)
   );

   // entry layout from lsb: start, end, final, last
   assign disp_entry  = {!emit.flush, 1'b0, old_end, old_start};
   assign flush_entry = {1'b1, 1'b1, new_end, new_start};
   assign wr0_valid   = advance && (emit.displace || emit.flush);
   assign wr1_valid   = advance && emit.displace && emit.flush;
   assign wr0_data    = emit.displace ? disp_entry : flush_entry;

   ssd_rsp_fifo #(
      .WIDTH(ENTRY_BITS)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr0_valid(wr0_valid),
      .wr0_data (wr0_data),
      .wr1_valid(wr1_valid),
      .wr1_data (flush_entry),
      .rd_ready (rsp_tready),
      .rd_valid (rsp_tvalid),
      .rd_data  (head),
      .room_two (room_two)
   );

   assign rsp_tdata = RSP_BITS'(head[2*INDEX_BITS-1:0]);
   assign rsp_tuser = head[2*INDEX_BITS];
   assign rsp_tlast = head[2*INDEX_BITS+1];

endmodule

### sv/ssd_seg_core.sv
// ----------------------------------------------------------------------------
// ssd_seg_core
// Segment tracking state and the per-sample close, keep and merge decisions.
// ----------------------------------------------------------------------------
module ssd_seg_core #(
   parameter int INDEX_BITS  = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   end_of_stream,
   input  logic [SAMPLE_BITS-1:0] silence_threshold,
   input  logic [INDEX_BITS-1:0]  min_silence_length,
   input  logic [INDEX_BITS-1:0]  min_active_gap,
   output ssd_pkg::emit_type      emit,
   output logic [INDEX_BITS-1:0]  old_start,
   output logic [INDEX_BITS-1:0]  old_end,
   output logic [INDEX_BITS-1:0]  new_start,
   output logic [INDEX_BITS-1:0]  new_end
);

   logic [INDEX_BITS-1:0] sample_index_ff, sample_index_in;
   logic                  in_silence_ff, in_silence_in;
   logic [INDEX_BITS-1:0] run_start_ff, run_start_in;
   logic                  pending_valid_ff, pending_valid_in;
   logic [INDEX_BITS-1:0] pending_start_ff, pending_start_in;
   logic [INDEX_BITS-1:0] pending_end_ff, pending_end_in;

   logic                  silent;
   logic                  keep;
   logic                  merge;
   logic                  pv_next;
   logic [INDEX_BITS-1:0] run_len;
   logic [INDEX_BITS-1:0] gap;

   always_comb begin
      silent  = sample < silence_threshold;
      run_len = sample_index_ff - run_start_ff;
      gap     = run_start_ff - pending_end_ff;
      keep    = !silent && in_silence_ff && (run_len > min_silence_length);
      merge   = keep && pending_valid_ff && (gap < min_active_gap);
      pv_next = pending_valid_ff || keep;

      pending_start_in = pending_start_ff;
      pending_end_in   = pending_end_ff;
      if (keep) begin
         pending_end_in = sample_index_ff;
         if (!merge) begin
            pending_start_in = run_start_ff;
         end
      end

      run_start_in = run_start_ff;
      if (silent && !in_silence_ff) begin
         run_start_in = sample_index_ff;
      end

      in_silence_in    = silent && !end_of_stream;
      pending_valid_in = pv_next && !end_of_stream;
      sample_index_in  = end_of_stream ? '0 : sample_index_ff + 1'b1;

      emit.displace = keep && pending_valid_ff && !merge;
      emit.flush    = end_of_stream && pv_next;
   end

   assign old_start = pending_start_ff;
   assign old_end   = pending_end_ff;
   assign new_start = pending_start_in;
   assign new_end   = pending_end_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff  <= '0;
         in_silence_ff    <= 1'b0;
         run_start_ff     <= '0;
         pending_valid_ff <= 1'b0;
         pending_start_ff <= '0;
         pending_end_ff   <= '0;
      end else if (step) begin
         sample_index_ff  <= sample_index_in;
         in_silence_ff    <= in_silence_in;
         run_start_ff     <= run_start_in;
         pending_valid_ff <= pending_valid_in;
         pending_start_ff <= pending_start_in;
         pending_end_ff   <= pending_end_in;
      end
   end

endmodule

### sv/ssd_rsp_fifo.sv
// ----------------------------------------------------------------------------
// ssd_rsp_fifo
// Small response buffer taking up to two entries per cycle, one out.
// ----------------------------------------------------------------------------
module ssd_rsp_fifo #(
   parameter int WIDTH = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr0_valid,
   input  logic [WIDTH-1:0] wr0_data,
   input  logic             wr1_valid,
   input  logic [WIDTH-1:0] wr1_data,
   input  logic             rd_ready,
   output logic             rd_valid,
   output logic [WIDTH-1:0] rd_data,
   output logic             room_two
);

   localparam int DEPTH    = ssd_pkg::RSP_FIFO_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   logic [WIDTH-1:0]    data_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0] wr_ptr_next;
   logic                pop;
   logic [CNT_BITS-1:0] count_after_pop;

   always_comb begin
      pop             = rd_ready && (count_ff != '0);
      count_after_pop = count_ff - CNT_BITS'(pop);
      room_two        = count_after_pop <= CNT_BITS'(DEPTH - 2);
      wr_ptr_next     = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;

      wr_ptr_in = wr_ptr_ff;
      if (wr0_valid && wr1_valid) begin
         wr_ptr_in = (wr_ptr_next == LAST_PTR) ? '0 : wr_ptr_next + 1'b1;
      end else if (wr0_valid) begin
         wr_ptr_in = wr_ptr_next;
      end

      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end

      count_in = count_after_pop + CNT_BITS'(wr0_valid) + CNT_BITS'(wr1_valid);
   end

   assign rd_valid = count_ff != '0;
   assign rd_data  = data_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr0_valid) begin
         data_ff[wr_ptr_ff] <= wr0_data;
      end
      if (wr0_valid && wr1_valid) begin
         data_ff[wr_ptr_next] <= wr1_data;
      end
   end

endmodule

### sv/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks for the silence segment detector.
// ----------------------------------------------------------------------------
module ssd_checker #(
   parameter int INDEX_BITS  = 24
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((2*INDEX_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);

   a_final_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of stream flush not marked last");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("response or held request survives reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_ready_after_drain: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !$past(req_tvalid) |-> req_tready)
      else $error("request stalled with empty response side");

endmodule

bind silence_segment_detector ssd_checker #(
   .INDEX_BITS (INDEX_BITS)
) u_ssd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
